FILE: sv/gaussian_blur_2d_clamped_core_assert.svh
// assertion macros shared by the blur core
`ifndef GAUSSIAN_BLUR_2D_CLAMPED_CORE_ASSERT_SVH
`define GAUSSIAN_BLUR_2D_CLAMPED_CORE_ASSERT_SVH

// same-cycle implication
`define GB2C_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GB2C_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gb2c_pkg.sv
// types, codes and the fixed kernel weight table of the blur core
package gb2c_pkg;

  localparam int HALF_WIDTH = 4;
  localparam int TAPS       = 2 * HALF_WIDTH + 1;
  localparam int TAP_W      = $clog2(TAPS);
  localparam int DIST_W     = $clog2(HALF_WIDTH + 1);
  localparam int WGT_W      = 16;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = WGT_W + 1 + SAMPLE_W;
  localparam int ACC_W      = 36;
  localparam int FRAC_W     = 16;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLUMNS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS    = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  CFG_DIM_RESET     = 7'd64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 36'sd32768;
  localparam logic signed [ACC_W-1:0] SAT_MAX    = 36'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_MIN    = -36'sd32768;

  // unsigned Q0.16 weight indexed by distance from the window center in x and y
  localparam logic [WGT_W-1:0] WEIGHT [0:HALF_WIDTH][0:HALF_WIDTH] = '{
    '{16'd2732, 16'd2411, 16'd1657, 16'd887, 16'd370},
    '{16'd2411, 16'd2127, 16'd1462, 16'd783, 16'd326},
    '{16'd1657, 16'd1462, 16'd1005, 16'd538, 16'd224},
    '{16'd887,  16'd783,  16'd538,  16'd288, 16'd120},
    '{16'd370,  16'd326,  16'd224,  16'd120, 16'd50}
  };

  typedef struct packed {
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample_value;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_value;
    logic                       last_of_frame;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

FILE: sv/gaussian_blur_2d_clamped_core.sv
// load: the bit-serial divider splits the linear position into column and row.
// fetch: divider, then one frame memory read and one multiply-accumulate per window
// tap, then pipeline drain and rounding.
// one item at a time; a finished result waits in the output register.
// synchronous reset clears positions, control and dims (64); frame memory is not cleared.
`include "gaussian_blur_2d_clamped_core_assert.svh"

module gaussian_blur_2d_clamped_core #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  gb2c_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output gb2c_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gb2c_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gb2c_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gb2c_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TOT_W  = $clog2(DEPTH + 1);
  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int X_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int Y_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int XS_W   = ((X_W > TAP_W) ? X_W : TAP_W) + 2;
  localparam int YS_W   = ((Y_W > TAP_W) ? Y_W : TAP_W) + 2;
  localparam int DCNT_W = $clog2(POS_W + 1);

  state_t state, state_next;

  logic [CFG_DATA_W-1:0] cols_reg, rows_reg;
  logic [COL_W-1:0]      cols_eff;
  logic [ROW_W-1:0]      rows_eff;
  logic [TOT_W-1:0]      total;

  logic [POS_W-1:0] load_pos, emit_pos;
  logic [POS_W-1:0] sel_pos, pos_in, pos_wrap;
  logic [TOT_W-1:0] pos_inc;
  logic             last_hit;

  logic                       op;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       item_last;

  // divider: quo starts as the position and ends as the column
  logic [POS_W-1:0]  quo;
  logic [ROW_W-1:0]  rem;
  logic [ROW_W:0]    trial;
  logic [DCNT_W-1:0] div_cnt;
  logic              div_done;
  logic [X_W-1:0]    x;
  logic [Y_W-1:0]    y;

  logic [TAP_W-1:0]  tap_a, tap_b;
  logic              last_tap;
  logic [DIST_W-1:0] dist_a, dist_b;
  logic signed [XS_W-1:0] nx, col_last;
  logic signed [YS_W-1:0] ny, row_last;
  logic [X_W-1:0]    nx_c;
  logic [Y_W-1:0]    ny_c;
  logic [POS_W-1:0]  rd_addr, store_addr;

  logic                       accept, issue, store_en, finish;
  logic                       v1, v2;
  logic [WGT_W-1:0]           w1;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc, acc_biased, acc_shift;
  logic signed [SAMPLE_W-1:0] filtered;

  logic signed [SAMPLE_W-1:0] frame_store [DEPTH];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg <= CFG_DIM_RESET;
      rows_reg <= CFG_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_COLUMNS: cols_reg <= cfg_data;
        REG_FRAME_ROWS:    rows_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates to the store dimension
  always_comb begin
    if (cols_reg == '0) begin
      cols_eff = COL_W'(1);
    end else if (int'(cols_reg) > MAX_COLUMNS) begin
      cols_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = COL_W'(cols_reg);
    end
    if (rows_reg == '0) begin
      rows_eff = ROW_W'(1);
    end else if (int'(rows_reg) > MAX_ROWS) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = ROW_W'(rows_reg);
    end
  end

  assign total = TOT_W'(cols_eff) * TOT_W'(rows_eff);

  // position of the accepted item and its successor
  assign sel_pos  = (item.operation == OP_FETCH) ? emit_pos : load_pos;
  assign pos_in   = (TOT_W'(sel_pos) < total) ? sel_pos : '0;
  assign pos_inc  = TOT_W'(pos_in) + TOT_W'(1);
  assign last_hit = (pos_inc == total);
  assign pos_wrap = last_hit ? '0 : POS_W'(pos_inc);

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE);

  assign div_done = (div_cnt == DCNT_W'(POS_W - 1));
  assign trial    = {rem, quo[POS_W-1]};
  assign x        = X_W'(quo);
  assign y        = Y_W'(rem);
  assign last_tap = (tap_a == TAP_W'(TAPS - 1)) && (tap_b == TAP_W'(TAPS - 1));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    store_en   = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = (op == OP_FETCH) ? ST_MAC : ST_STORE;
      end
      ST_STORE: begin
        store_en   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MAC: begin
        issue = 1'b1;
        if (last_tap) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1 && !v2) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // positions, divider and tap counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      emit_pos <= '0;
      div_cnt  <= '0;
      tap_a    <= '0;
      tap_b    <= '0;
    end else begin
      if (accept) begin
        if (item.operation == OP_FETCH) begin
          emit_pos <= pos_wrap;
        end else begin
          load_pos <= pos_wrap;
        end
        div_cnt <= '0;
        tap_a   <= '0;
        tap_b   <= '0;
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt + DCNT_W'(1);
      end else if (issue) begin
        if (tap_b == TAP_W'(TAPS - 1)) begin
          tap_b <= '0;
          tap_a <= tap_a + TAP_W'(1);
        end else begin
          tap_b <= tap_b + TAP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= item.operation;
      sample    <= item.sample_value;
      item_last <= last_hit;
      quo       <= pos_in;
      rem       <= '0;
    end else if (state == ST_DIV) begin
      // restoring division, one quotient bit per cycle
      if (trial >= {1'b0, rows_eff}) begin
        rem <= ROW_W'(trial - {1'b0, rows_eff});
        quo <= POS_W'({quo, 1'b1});
      end else begin
        rem <= ROW_W'(trial);
        quo <= POS_W'({quo, 1'b0});
      end
    end
  end

  // clamped neighbor coordinates replicate the border
  assign col_last = XS_W'(cols_eff) - XS_W'(1);
  assign row_last = YS_W'(rows_eff) - YS_W'(1);
  assign nx = XS_W'(x) + XS_W'(tap_a) - XS_W'(HALF_WIDTH);
  assign ny = YS_W'(y) + YS_W'(tap_b) - YS_W'(HALF_WIDTH);

  always_comb begin
    if (nx < 0) begin
      nx_c = '0;
    end else if (nx > col_last) begin
      nx_c = X_W'(col_last);
    end else begin
      nx_c = X_W'(nx);
    end
    if (ny < 0) begin
      ny_c = '0;
    end else if (ny > row_last) begin
      ny_c = Y_W'(row_last);
    end else begin
      ny_c = Y_W'(ny);
    end
  end

  assign dist_a = (tap_a >= TAP_W'(HALF_WIDTH)) ? DIST_W'(tap_a - TAP_W'(HALF_WIDTH))
                                                : DIST_W'(TAP_W'(HALF_WIDTH) - tap_a);
  assign dist_b = (tap_b >= TAP_W'(HALF_WIDTH)) ? DIST_W'(tap_b - TAP_W'(HALF_WIDTH))
                                                : DIST_W'(TAP_W'(HALF_WIDTH) - tap_b);

  assign rd_addr    = POS_W'(nx_c) * POS_W'(MAX_ROWS) + POS_W'(ny_c);
  assign store_addr = POS_W'(x) * POS_W'(MAX_ROWS) + POS_W'(y);

  // frame memory
  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_store[store_addr] <= sample;
    end
    if (issue) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      w1 <= WEIGHT[dist_a][dist_b];
    end
    if (v1) begin
      prod <= $signed({1'b0, w1}) * rd_data;
    end
    if (accept) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, then saturate
  assign acc_biased = acc + ROUND_HALF;
  assign acc_shift  = acc_biased >>> FRAC_W;

  always_comb begin
    if (acc_shift > SAT_MAX) begin
      filtered = SAMPLE_W'(SAT_MAX);
    end else if (acc_shift < SAT_MIN) begin
      filtered = SAMPLE_W'(SAT_MIN);
    end else begin
      filtered = SAMPLE_W'(acc_shift);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.filtered_value <= filtered;
      result.last_of_frame  <= item_last;
    end
  end

  `GB2C_ASSERT_IMP(a_drained, clk, rst, state == ST_FINISH, !v1 && !v2,
    "taps still in flight at rounding")
  `GB2C_ASSERT_IMP(a_result_src, clk, rst, $rose(result_valid), $past(state) == ST_FINISH,
    "result raised outside the finish step")
  `GB2C_ASSERT_IMP(a_coord_range, clk, rst, state == ST_MAC,
    (int'(x) < int'(cols_eff)) && (int'(y) < int'(rows_eff)), "divider gave out-of-frame point")
  `GB2C_ASSERT_NXT(a_mac_start, clk, rst, (state == ST_DIV) && div_done && (op == OP_FETCH),
    (tap_a == '0) && (tap_b == '0) && (acc == '0), "window walk did not start clean")

endmodule
